FILE: design/mbar_pkg.sv
// Shared constants, codes, types and helpers for the mouse button action remapper.
package mbar_pkg;

  localparam int NUM_BTN     = 5;
  localparam int NUM_SRC     = 7;
  localparam int SRC_W       = 3;
  localparam int ENTRY_W     = 6;
  localparam int BTN_W       = 2;
  localparam int MAX_RESULTS = 10;
  localparam int CNT_W       = 4;
  localparam int OP_W        = 2;
  localparam int TYPE_W      = 2;
  localparam int CODE_W      = 10;
  localparam int VAL_W       = 16;
  localparam int HOLD_W      = 16;
  localparam int TABLE_W     = 42;
  localparam int CFG_W       = 42;
  localparam int CFG_IDX_W   = 2;
  localparam int TDATA_W     = 32;

  localparam int TIMER_BITS_DEF    = 16;
  localparam int DOUBLE_GAP_MS_DEF = 18;

  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd150;
  localparam logic [TABLE_W-1:0] TABLE_RESET = 42'd628173083268;

  localparam logic [CODE_W-1:0] KEY_BASE   = 10'd272;
  localparam logic [CODE_W-1:0] AXIS_X     = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_Y     = 10'd1;
  localparam logic [CODE_W-1:0] AXIS_WHEEL = 10'd8;

  localparam logic [VAL_W-1:0] KEY_UP      = 16'd0;
  localparam logic [VAL_W-1:0] KEY_DOWN    = 16'd1;
  localparam logic [VAL_W-1:0] SCROLL_UP   = 16'd1;
  localparam logic [VAL_W-1:0] SCROLL_DOWN = 16'hFFFF;

  localparam logic [SRC_W-1:0] WHL_UP_SRC = 3'd5;
  localparam logic [SRC_W-1:0] WHL_DN_SRC = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE = 2'd1;

  typedef enum logic [OP_W-1:0] {OP_TICK, OP_KEY, OP_REL, OP_SYNC} op_e;
  typedef enum logic [TYPE_W-1:0] {T_KEY, T_REL, T_SYNC, T_PAUSE} otype_e;
  typedef enum logic [2:0] {
    MODE_NONE, MODE_CLICK, MODE_HOLD, MODE_DOUBLE, MODE_TAPDBL, MODE_SCROLL
  } mode_e;
  // ONE: single result, PAIR: result then sync
  typedef enum logic [2:0] {EV_NONE, EV_ONE, EV_PAIR, EV_CLICK, EV_DCLICK} ev_e;

  typedef struct packed {
    ev_e                          kind;
    otype_e                       typ;
    logic [CODE_W-1:0]            code;
    logic [VAL_W-1:0]             value;
    logic [CNT_W-1:0]             ev_len;
    logic [CNT_W-1:0]             total;
    logic [NUM_BTN-1:0]           comm;
    logic [NUM_BTN-1:0][BTN_W-1:0] comm_btn;
  } plan_t;

  // target button, with the unused code mapped to left
  function automatic logic [BTN_W-1:0] btn_of(logic [ENTRY_W-1:0] entry);
    logic [BTN_W-1:0] b;
    b = entry[4:3];
    return (b == 2'd3) ? 2'd0 : b;
  endfunction

  function automatic logic [CODE_W-1:0] btn_code(logic [BTN_W-1:0] b);
    return KEY_BASE + CODE_W'(b);
  endfunction

  function automatic logic [VAL_W-1:0] scroll_of(logic [ENTRY_W-1:0] entry);
    return entry[5] ? SCROLL_DOWN : SCROLL_UP;
  endfunction

endpackage

FILE: design/mouse_button_action_remapper.sv
// Top level of the mouse button action remapper: state, config, result sequencing.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready       | tdata: operation, event_code, event_value
//  m_axis   | out | m_axis_tvalid/tready       | tdata: out_type, out_code, out_value; tlast
//  cfg      | in  | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
//
// An item is decoded in its accept cycle; its results then leave one per cycle while
// m_axis is ready, at most 10 of them through the single result port. The next item
// is accepted in the cycle the last result is taken.
// Reset is asynchronous: registers return to hold 150 and the default table,
// flags and timers clear. A stall on m_axis holds the current result in place.
module mouse_button_action_remapper import mbar_pkg::*; #(
  parameter int TIMER_BITS    = TIMER_BITS_DEF,
  parameter int DOUBLE_GAP_MS = DOUBLE_GAP_MS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,  // [1:0] operation, [11:2] event_code,
                                              // [27:12] event_value
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata,  // [1:0] out_type, [11:2] out_code,
                                              // [27:12] out_value
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [HOLD_W-1:0]                  hold_q;
  logic [TABLE_W-1:0]                 table_q;
  logic [NUM_BTN-1:0]                 pending_q, pending_d;
  logic [NUM_BTN-1:0]                 held_q, held_d;
  logic [NUM_BTN-1:0][TIMER_BITS-1:0] elapsed_q, elapsed_d;
  plan_t                              plan_q, plan_d;
  logic [NUM_BTN-1:0]                 comm_q;
  logic [CNT_W-1:0]                   step_q;
  logic                               busy_q;

  logic              in_fire;
  logic              out_fire;
  logic              out_last;
  logic [CNT_W-1:0]  cstep;
  logic [CNT_W-1:0]  kc;
  logic [BTN_W-1:0]  low_btn;
  otype_e            o_typ;
  logic [CODE_W-1:0] o_code;
  logic [VAL_W-1:0]  o_val;

  mbar_plan #(
    .TIMER_BITS(TIMER_BITS)
  ) u_plan (
    .op_i      (s_axis_tdata[1:0]),
    .code_i    (s_axis_tdata[11:2]),
    .value_i   (s_axis_tdata[27:12]),
    .hold_i    (hold_q),
    .table_i   (table_q),
    .pending_i (pending_q),
    .held_i    (held_q),
    .elapsed_i (elapsed_q),
    .plan_o    (plan_d),
    .pending_o (pending_d),
    .held_o    (held_d),
    .elapsed_o (elapsed_d)
  );

  assign out_last      = (step_q == plan_q.total - 4'd1);
  assign m_axis_tvalid = busy_q;
  assign out_fire      = busy_q && m_axis_tready;
  assign s_axis_tready = !busy_q || (m_axis_tready && out_last);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cstep = step_q - plan_q.ev_len;
  assign kc    = ((plan_q.kind == EV_DCLICK) && (step_q > 4'd4)) ? step_q - 4'd5 : step_q;

  always_comb begin
    low_btn = '0;
    for (int s = NUM_BTN - 1; s >= 0; s--) begin
      if (comm_q[s]) low_btn = plan_q.comm_btn[s];
    end
  end

  always_comb begin
    o_typ  = T_SYNC;
    o_code = '0;
    o_val  = '0;
    if (step_q < plan_q.ev_len) begin
      case (plan_q.kind)
        EV_ONE: begin
          o_typ  = plan_q.typ;
          o_code = plan_q.code;
          o_val  = plan_q.value;
        end
        EV_PAIR: begin
          if (step_q == 4'd0) begin
            o_typ  = plan_q.typ;
            o_code = plan_q.code;
            o_val  = plan_q.value;
          end
        end
        EV_CLICK, EV_DCLICK: begin
          if ((plan_q.kind == EV_DCLICK) && (step_q == 4'd4)) begin
            o_typ = T_PAUSE;
            o_val = VAL_W'(DOUBLE_GAP_MS);
          end else if (kc[1:0] == 2'd0) begin
            o_typ  = T_KEY;
            o_code = plan_q.code;
            o_val  = KEY_DOWN;
          end else if (kc[1:0] == 2'd2) begin
            o_typ  = T_KEY;
            o_code = plan_q.code;
            o_val  = KEY_UP;
          end
        end
        default: ;
      endcase
    end else if (!cstep[0]) begin
      o_typ  = T_KEY;
      o_code = btn_code(low_btn);
      o_val  = KEY_DOWN;
    end
  end

  assign m_axis_tdata = {4'd0, o_val, o_code, o_typ};
  assign m_axis_tlast = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= HOLD_RESET;
      table_q <= TABLE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_HOLD) begin
        hold_q <= cfg_wdata_i[HOLD_W-1:0];
      end else if (cfg_addr_i == REG_TABLE) begin
        table_q <= cfg_wdata_i[TABLE_W-1:0];
      end
    end
  end

  // a new item overrides the retiring last result of the previous one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      held_q    <= '0;
      elapsed_q <= '0;
      busy_q    <= 1'b0;
      step_q    <= '0;
      comm_q    <= '0;
      plan_q    <= '0;
    end else if (in_fire) begin
      pending_q <= pending_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
      busy_q    <= (plan_d.total != '0);
      step_q    <= '0;
      comm_q    <= plan_d.comm;
      plan_q    <= plan_d;
    end else if (out_fire) begin
      if (out_last) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 4'd1;
      end
      if ((step_q >= plan_q.ev_len) && cstep[0]) begin
        comm_q <= comm_q & (comm_q - 1'b1);
      end
    end
  end

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q < plan_q.total))
    else $error("result step beyond planned count");

  a_flags_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q & held_q) == '0)
    else $error("button both pending and held");

  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && busy_q) |-> (m_axis_tready && out_last))
    else $error("item accepted while results remain");

  a_commits_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last) |-> (comm_q & (comm_q - 1'b1)) == '0)
    else $error("commit results left over at end of item");

endmodule

FILE: design/mbar_plan.sv
// Decodes one item into a result plan and the next button timing state.
module mbar_plan import mbar_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic [OP_W-1:0]                    op_i,
  input  logic [CODE_W-1:0]                  code_i,
  input  logic [VAL_W-1:0]                   value_i,
  input  logic [HOLD_W-1:0]                  hold_i,
  input  logic [TABLE_W-1:0]                 table_i,
  input  logic [NUM_BTN-1:0]                 pending_i,
  input  logic [NUM_BTN-1:0]                 held_i,
  input  logic [NUM_BTN-1:0][TIMER_BITS-1:0] elapsed_i,
  output plan_t                              plan_o,
  output logic [NUM_BTN-1:0]                 pending_o,
  output logic [NUM_BTN-1:0]                 held_o,
  output logic [NUM_BTN-1:0][TIMER_BITS-1:0] elapsed_o
);

  localparam int CMP_W = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

  logic [NUM_SRC-1:0][ENTRY_W-1:0] ent;
  logic [SRC_W-1:0]                key_src;
  logic [SRC_W-1:0]                whl_src;
  logic [ENTRY_W-1:0]              key_ent;
  logic [ENTRY_W-1:0]              whl_ent;
  logic                            is_btn;
  ev_e                             kind;
  otype_e                          typ;
  logic [CODE_W-1:0]               code;
  logic [VAL_W-1:0]                value;
  logic [NUM_BTN-1:0]              pend_ev;
  logic [NUM_BTN-1:0]              held_ev;
  logic [CNT_W-1:0]                ev_len;
  logic [2:0]                      allowed;
  logic [2:0]                      cnt;
  logic [NUM_BTN-1:0]              comm;
  logic [NUM_BTN-1:0][BTN_W-1:0]   comm_btn;

  assign ent     = table_i;
  assign key_src = SRC_W'(code_i - KEY_BASE);
  assign whl_src = value_i[VAL_W-1] ? WHL_DN_SRC : WHL_UP_SRC;
  assign key_ent = ent[key_src];
  assign whl_ent = ent[whl_src];
  assign is_btn  = (code_i >= KEY_BASE) && (code_i < KEY_BASE + CODE_W'(NUM_BTN));

  always_comb begin
    kind      = EV_NONE;
    typ       = T_KEY;
    code      = code_i;
    value     = value_i;
    pend_ev   = pending_i;
    held_ev   = held_i;
    elapsed_o = elapsed_i;
    case (op_e'(op_i))
      OP_TICK: begin
        for (int s = 0; s < NUM_BTN; s++) begin
          if (pending_i[s] && (elapsed_i[s] != '1)) begin
            elapsed_o[s] = elapsed_i[s] + 1'b1;
          end
        end
      end
      OP_KEY: begin
        if (!is_btn) begin
          kind = EV_PAIR;
        end else if ((value_i == KEY_UP) || (value_i == KEY_DOWN)) begin
          code = btn_code(btn_of(key_ent));
          case (mode_e'(key_ent[2:0]))
            MODE_CLICK: begin
              if (value_i == KEY_DOWN) kind = EV_CLICK;
            end
            MODE_HOLD: begin
              kind = EV_PAIR;
            end
            MODE_DOUBLE: begin
              if (value_i == KEY_DOWN) kind = EV_DCLICK;
            end
            MODE_TAPDBL: begin
              if (value_i == KEY_DOWN) begin
                pend_ev[key_src]   = 1'b1;
                held_ev[key_src]   = 1'b0;
                elapsed_o[key_src] = '0;
              end else if (pending_i[key_src]) begin
                kind             = EV_DCLICK;
                pend_ev[key_src] = 1'b0;
              end else if (held_i[key_src]) begin
                kind             = EV_PAIR;
                held_ev[key_src] = 1'b0;
              end
            end
            MODE_SCROLL: begin
              if (value_i == KEY_DOWN) begin
                kind  = EV_PAIR;
                typ   = T_REL;
                code  = AXIS_WHEEL;
                value = scroll_of(key_ent);
              end
            end
            default: ;
          endcase
        end
      end
      OP_REL: begin
        if ((code_i == AXIS_X) || (code_i == AXIS_Y)) begin
          kind = EV_ONE;
          typ  = T_REL;
        end else if ((code_i == AXIS_WHEEL) && (value_i != '0)) begin
          code = btn_code(btn_of(whl_ent));
          case (mode_e'(whl_ent[2:0]))
            MODE_CLICK, MODE_HOLD:    kind = EV_CLICK;
            MODE_DOUBLE, MODE_TAPDBL: kind = EV_DCLICK;
            MODE_SCROLL: begin
              kind  = EV_PAIR;
              typ   = T_REL;
              code  = AXIS_WHEEL;
              value = scroll_of(whl_ent);
            end
            default: ;
          endcase
        end
      end
      OP_SYNC: begin
        kind  = EV_ONE;
        typ   = T_SYNC;
        code  = '0;
        value = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (kind)
      EV_ONE:    ev_len = 4'd1;
      EV_PAIR:   ev_len = 4'd2;
      EV_CLICK:  ev_len = 4'd4;
      EV_DCLICK: ev_len = 4'd9;
      default:   ev_len = 4'd0;
    endcase
  end

  // commits fill the remaining result slots two at a time, lowest source first
  assign allowed = 3'((CNT_W'(MAX_RESULTS) - ev_len) >> 1);

  always_comb begin
    cnt  = '0;
    comm = '0;
    for (int s = 0; s < NUM_BTN; s++) begin
      comm_btn[s] = btn_of(ent[s]);
      if (pend_ev[s] && (CMP_W'(elapsed_o[s]) >= CMP_W'(hold_i)) && (cnt < allowed)) begin
        comm[s] = 1'b1;
        cnt     = cnt + 3'd1;
      end
    end
  end

  assign pending_o = pend_ev & ~comm;
  assign held_o    = held_ev | comm;

  always_comb begin
    plan_o.kind     = kind;
    plan_o.typ      = typ;
    plan_o.code     = code;
    plan_o.value    = value;
    plan_o.ev_len   = ev_len;
    plan_o.total    = ev_len + {cnt, 1'b0};
    plan_o.comm     = comm;
    plan_o.comm_btn = comm_btn;
  end

endmodule

FILE: sim/mbar_checker.sv
// Checker for the mouse button action remapper: watches both streams, predicts and compares.
`timescale 1ns / 1ps
module mbar_checker import mbar_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TDATA_W-1:0]   in_data_i,     // [1:0] operation, [11:2] event_code,
                                              // [27:12] event_value
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [TDATA_W-1:0]   out_data_i,    // [1:0] out_type, [11:2] out_code,
                                              // [27:12] out_value
  input  logic                 out_last_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   fail_count_o,
  output int                   outstanding_o,
  output int                   items_o,
  output int                   results_o,
  output int                   commits_o
);

  typedef struct packed {
    otype_e            typ;
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  value;
    logic              last;
  } mouse_result_t;

  localparam logic [TIMER_BITS_DEF-1:0] TIMER_MAX = '1;
  localparam logic [VAL_W-1:0]          GAP_MS    = VAL_W'(DOUBLE_GAP_MS_DEF);

  logic [HOLD_W-1:0]         hold_ms;
  logic [TABLE_W-1:0]        actions;
  logic [NUM_BTN-1:0]        pending;
  logic [NUM_BTN-1:0]        held;
  logic [TIMER_BITS_DEF-1:0] elapsed [NUM_BTN];

  mouse_result_t burst[$];
  mouse_result_t expected_results[$];

  function automatic logic [ENTRY_W-1:0] entry_at(int src);
    return actions[ENTRY_W*src +: ENTRY_W];
  endfunction

  // button field 3 falls back to left
  function automatic logic [CODE_W-1:0] target_key(logic [ENTRY_W-1:0] e);
    return (&e[4:3]) ? KEY_BASE : KEY_BASE + CODE_W'(e[4:3]);
  endfunction

  function automatic logic [VAL_W-1:0] wheel_delta(logic [ENTRY_W-1:0] e);
    return e[5] ? SCROLL_DOWN : SCROLL_UP;
  endfunction

  function automatic void emit(otype_e t, logic [CODE_W-1:0] c, logic [VAL_W-1:0] v);
    if (burst.size() < MAX_RESULTS) burst.push_back('{t, c, v, 1'b0});
  endfunction

  function automatic void emit_sync();
    emit(T_SYNC, '0, '0);
  endfunction

  function automatic void emit_click(logic [CODE_W-1:0] key);
    emit(T_KEY, key, KEY_DOWN);
    emit_sync();
    emit(T_KEY, key, KEY_UP);
    emit_sync();
  endfunction

  function automatic void emit_double(logic [CODE_W-1:0] key);
    emit_click(key);
    emit(T_PAUSE, '0, GAP_MS);
    emit_click(key);
  endfunction

  function automatic void button_event(int src, logic [VAL_W-1:0] v);
    logic [ENTRY_W-1:0] e;
    logic [CODE_W-1:0]  key;
    e   = entry_at(src);
    key = target_key(e);
    if (v != KEY_UP && v != KEY_DOWN) return;
    case (e[2:0])
      MODE_CLICK:  if (v == KEY_DOWN) emit_click(key);
      MODE_HOLD: begin
        emit(T_KEY, key, v);
        emit_sync();
      end
      MODE_DOUBLE: if (v == KEY_DOWN) emit_double(key);
      MODE_TAPDBL: begin
        if (v == KEY_DOWN) begin
          pending[src] = 1'b1;
          held[src]    = 1'b0;
          elapsed[src] = '0;
        end else if (pending[src]) begin
          emit_double(key);
          pending[src] = 1'b0;
        end else if (held[src]) begin
          emit(T_KEY, key, KEY_UP);
          emit_sync();
          held[src] = 1'b0;
        end
      end
      MODE_SCROLL: if (v == KEY_DOWN) begin
        emit(T_REL, AXIS_WHEEL, wheel_delta(e));
        emit_sync();
      end
      default: ;
    endcase
  endfunction

  function automatic void wheel_event(int src);
    logic [ENTRY_W-1:0] e;
    e = entry_at(src);
    case (e[2:0])
      MODE_CLICK, MODE_HOLD:   emit_click(target_key(e));
      MODE_DOUBLE, MODE_TAPDBL: emit_double(target_key(e));
      MODE_SCROLL: begin
        emit(T_REL, AXIS_WHEEL, wheel_delta(e));
        emit_sync();
      end
      default: ;
    endcase
  endfunction

  // turn due tap-double presses into holds, as far as the result limit allows
  function automatic void commit_holds();
    for (int s = 0; s < NUM_BTN; s++) begin
      if (pending[s] && elapsed[s] >= hold_ms) begin
        if (burst.size() + 2 > MAX_RESULTS) return;
        emit(T_KEY, target_key(entry_at(s)), KEY_DOWN);
        emit_sync();
        pending[s] = 1'b0;
        held[s]    = 1'b1;
        commits_o++;
      end
    end
  endfunction

  function automatic void predict_remap(logic [TDATA_W-1:0] d);
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  val;
    code = d[11:2];
    val  = d[27:12];
    burst.delete();
    case (op_e'(d[1:0]))
      OP_TICK: begin
        for (int s = 0; s < NUM_BTN; s++)
          if (pending[s] && elapsed[s] != TIMER_MAX) elapsed[s]++;
      end
      OP_KEY: begin
        if (code >= KEY_BASE && code < KEY_BASE + CODE_W'(NUM_BTN)) begin
          button_event(int'(code - KEY_BASE), val);
        end else begin
          emit(T_KEY, code, val);
          emit_sync();
        end
      end
      OP_REL: begin
        if (code == AXIS_X || code == AXIS_Y) begin
          emit(T_REL, code, val);
        end else if (code == AXIS_WHEEL && val != '0) begin
          wheel_event(val[VAL_W-1] ? int'(WHL_DN_SRC) : int'(WHL_UP_SRC));
        end
      end
      OP_SYNC: emit_sync();
      default: ;
    endcase
    commit_holds();
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) expected_results.push_back(burst[i]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d: %s, got %0h, expected %0h", results_o, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mouse_result_t got;
    mouse_result_t want;
    if (!rst_ni) begin
      hold_ms  = HOLD_RESET;
      actions  = TABLE_RESET;
      pending  = '0;
      held     = '0;
      foreach (elapsed[i]) elapsed[i] = '0;
      expected_results.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      items_o       = 0;
      results_o     = 0;
      commits_o     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_HOLD) hold_ms = cfg_wdata_i[HOLD_W-1:0];
        else if (cfg_addr_i == REG_TABLE) actions = cfg_wdata_i[TABLE_W-1:0];
      end
      // new item queues behind results still owed; results pop from the front
      if (in_valid_i && in_ready_i) begin
        predict_remap(in_data_i);
        items_o++;
      end
      if (out_valid_i && out_ready_i) begin
        got = {out_data_i[1:0], out_data_i[11:2], out_data_i[27:12], out_last_i};
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", got, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.typ != want.typ) report_mismatch("out_type", got.typ, want.typ);
          if (got.code != want.code) report_mismatch("out_code", got.code, want.code);
          if (got.value != want.value) report_mismatch("out_value", got.value, want.value);
          if (got.last != want.last) report_mismatch("tlast", got.last, want.last);
        end
        results_o++;
      end
      outstanding_o = expected_results.size();
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the mouse button action remapper: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb import mbar_pkg::*; ();

  localparam int LIMIT    = 60000;
  localparam int HOLD_OFF = 80;
  localparam int PHASES   = 8;
  localparam int PHASE_N  = 28;

  localparam logic [BTN_W-1:0] TGT_LEFT   = 2'd0;
  localparam logic [BTN_W-1:0] TGT_RIGHT  = 2'd1;
  localparam logic [BTN_W-1:0] TGT_MIDDLE = 2'd2;
  localparam logic [BTN_W-1:0] TGT_UNUSED = 2'd3;
  localparam logic [2:0]       MODE_UNDEF = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_HI = 2'd3;
  localparam logic [VAL_W-1:0]  KEY_REPEAT  = 16'd2;
  localparam logic [CODE_W-1:0] KEY_UNKNOWN = 10'd100;

  localparam int IDX_LEFT   = 0;
  localparam int IDX_RIGHT  = 1;
  localparam int IDX_MIDDLE = 2;
  localparam int IDX_SIDE   = 3;
  localparam int IDX_EXTRA  = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;   // [1:0] operation, [11:2] event_code,
                                        // [27:12] event_value
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [TDATA_W-1:0]   m_axis_tdata;   // [1:0] out_type, [11:2] out_code,
                                        // [27:12] out_value
  logic                 m_axis_tlast;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  int fail_count, outstanding, n_items, n_results, n_commits;
  int n_offered   = 0;
  int cycle_count = 0;
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  mouse_button_action_remapper DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  mbar_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .out_last_i(m_axis_tlast),
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .outstanding_o(outstanding),
    .items_o(n_items), .results_o(n_results), .commits_o(n_commits)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d results still expected", cycle_count, outstanding);
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 36);
    end
  end

  function automatic logic [ENTRY_W-1:0] act(logic [2:0] mode, logic [BTN_W-1:0] b,
                                             logic down);
    return {down, b, mode};
  endfunction

  function automatic logic [CODE_W-1:0] key_of(int src);
    return KEY_BASE + CODE_W'(src);
  endfunction

  task automatic send_item(op_e op, logic [CODE_W-1:0] code, logic [VAL_W-1:0] val);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({val, code, op});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_offered++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, CODE_W'($urandom_range(767)), VAL_W'($urandom));
  endtask

  // waits until the block has drained, then writes one register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic noise_item();
    int pick;
    logic [CODE_W-1:0] code;
    logic [VAL_W-1:0]  val;
    pick = $urandom_range(99);
    code = CODE_W'($urandom_range(767));
    val  = VAL_W'($urandom);
    if (pick < 20) send_item(OP_TICK, code, val);
    else if (pick < 35) send_item(OP_KEY, code, val);
    else if (pick < 55)
      send_item(OP_KEY, key_of($urandom_range(NUM_BTN-1)), VAL_W'($urandom_range(2)));
    else if (pick < 62) send_item(OP_KEY, key_of($urandom_range(NUM_BTN-1)), val);
    else if (pick < 66)
      send_item(OP_KEY, $urandom_range(1) ? KEY_BASE - 10'd1 : key_of(NUM_BTN), val);
    else if (pick < 80) send_item(OP_REL, $urandom_range(1) ? AXIS_X : AXIS_Y, val);
    else if (pick < 92) begin
      case ($urandom_range(3))
        0: val = '0;
        1: val = SCROLL_UP;
        2: val = SCROLL_DOWN;
        default: ;
      endcase
      send_item(OP_REL, AXIS_WHEEL, val);
    end
    else if (pick < 96) send_item(OP_REL, code, val);
    else send_item(OP_SYNC, code, val);
  endtask

  // press, some ticks with occasional noise or repeats, release; sometimes a chord
  task automatic press_gesture();
    int a, b, ticks, pick;
    bit chord;
    a     = $urandom_range(NUM_BTN-1);
    b     = $urandom_range(NUM_BTN-1);
    chord = ($urandom_range(3) == 0);
    ticks = $urandom_range(12);
    send_item(OP_KEY, key_of(a), KEY_DOWN);
    if (chord) send_item(OP_KEY, key_of(b), KEY_DOWN);
    repeat (ticks) begin
      pick = $urandom_range(9);
      if (pick < 8) send_tick();
      else if (pick == 8) noise_item();
      else send_item(OP_KEY, key_of(a), KEY_REPEAT);
    end
    send_item(OP_KEY, key_of(a), KEY_UP);
    if (chord) send_item(OP_KEY, key_of(b), KEY_UP);
  endtask

  task automatic random_setup(int phase);
    logic [HOLD_W-1:0]  hold;
    logic [TABLE_W-1:0] acts;
    hold = ($urandom_range(3) == 0) ? HOLD_W'($urandom) : HOLD_W'($urandom_range(8));
    if ($urandom_range(9) < 7) begin
      for (int i = 0; i < NUM_SRC; i++)
        acts[ENTRY_W*i +: ENTRY_W] = act($urandom_range(1) ? MODE_TAPDBL : 3'($urandom),
                                         BTN_W'($urandom), 1'($urandom));
    end else begin
      acts = {10'($urandom), $urandom};
    end
    case (phase)
      0: begin
        hold = '0;
        acts = '1;
      end
      1: hold = '1;
      2: acts = '0;
      default: ;
    endcase
    write_reg(REG_HOLD, CFG_W'(hold));
    write_reg(REG_TABLE, CFG_W'(acts));
  endtask

  initial begin
    logic [TABLE_W-1:0] tbl_a, tbl_b, tbl_c;
    int target;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: pass-through paths and field extremes
    send_tick();
    send_item(OP_KEY, '0, 16'h8000);
    send_item(OP_KEY, 10'd767, 16'h7FFF);
    send_item(OP_REL, AXIS_X, 16'h7FFF);
    send_item(OP_REL, AXIS_Y, 16'h8000);
    send_item(OP_REL, 10'd2, 16'd5);
    send_item(OP_REL, AXIS_WHEEL, '0);
    send_item(OP_SYNC, '0, '0);

    // writes to unmapped indexes must not land anywhere
    write_reg(REG_BAD_LO, '1);
    write_reg(REG_BAD_HI, '1);
    tbl_a = {act(MODE_TAPDBL, TGT_MIDDLE, 1'b0), act(MODE_UNDEF, TGT_RIGHT, 1'b0),
             act(MODE_SCROLL, TGT_LEFT, 1'b1), act(MODE_DOUBLE, TGT_RIGHT, 1'b0),
             act(MODE_HOLD, TGT_MIDDLE, 1'b0), act(MODE_CLICK, TGT_RIGHT, 1'b0),
             act(MODE_TAPDBL, TGT_UNUSED, 1'b0)};
    write_reg(REG_TABLE, CFG_W'(tbl_a));
    write_reg(REG_HOLD, CFG_W'(16'd2));
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_DOWN);
    send_tick();
    send_tick();
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_REPEAT);
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_UP);
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_DOWN);
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_UP);
    send_item(OP_KEY, key_of(IDX_RIGHT), KEY_DOWN);
    send_item(OP_KEY, key_of(IDX_RIGHT), KEY_UP);
    send_item(OP_KEY, key_of(IDX_MIDDLE), KEY_DOWN);
    send_item(OP_KEY, key_of(IDX_MIDDLE), KEY_UP);
    send_item(OP_KEY, key_of(IDX_SIDE), KEY_DOWN);
    send_item(OP_KEY, key_of(IDX_EXTRA), KEY_DOWN);
    send_item(OP_REL, AXIS_WHEEL, SCROLL_UP);
    send_item(OP_REL, AXIS_WHEEL, SCROLL_DOWN);
    send_item(OP_KEY, key_of(NUM_BTN), KEY_DOWN);
    write_reg(REG_HOLD, '0);
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_DOWN);
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_UP);

    // result limit: lowering the hold time makes five presses due at once
    tbl_b = {act(MODE_DOUBLE, TGT_RIGHT, 1'b0), act(MODE_DOUBLE, TGT_LEFT, 1'b0),
             act(MODE_TAPDBL, TGT_MIDDLE, 1'b0), act(MODE_TAPDBL, TGT_RIGHT, 1'b0),
             act(MODE_TAPDBL, TGT_LEFT, 1'b0), act(MODE_TAPDBL, TGT_RIGHT, 1'b0),
             act(MODE_TAPDBL, TGT_MIDDLE, 1'b0)};
    write_reg(REG_TABLE, CFG_W'(tbl_b));
    write_reg(REG_HOLD, CFG_W'(16'd1000));
    for (int s = 0; s < NUM_BTN; s++) send_item(OP_KEY, key_of(s), KEY_DOWN);
    send_tick();
    write_reg(REG_HOLD, '0);
    send_item(OP_KEY, KEY_UNKNOWN, KEY_DOWN);
    send_item(OP_SYNC, '0, '0);
    write_reg(REG_HOLD, CFG_W'(16'd1000));
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_DOWN);
    write_reg(REG_HOLD, '0);
    send_item(OP_REL, AXIS_WHEEL, SCROLL_UP);
    send_tick();
    for (int s = 0; s < NUM_BTN; s++) send_item(OP_KEY, key_of(s), KEY_UP);

    // mode changed under a pending press
    write_reg(REG_HOLD, CFG_W'(16'd1000));
    send_item(OP_KEY, key_of(IDX_RIGHT), KEY_DOWN);
    tbl_c = tbl_b;
    tbl_c[ENTRY_W*IDX_RIGHT +: ENTRY_W] = act(MODE_CLICK, TGT_MIDDLE, 1'b0);
    write_reg(REG_TABLE, CFG_W'(tbl_c));
    send_item(OP_KEY, key_of(IDX_RIGHT), KEY_UP);
    write_reg(REG_HOLD, '0);
    send_tick();
    send_item(OP_KEY, key_of(IDX_RIGHT), KEY_UP);
    write_reg(REG_TABLE, CFG_W'(tbl_b));
    send_item(OP_KEY, key_of(IDX_RIGHT), KEY_UP);

    // hold reached by ticks alone, gapless
    write_reg(REG_HOLD, CFG_W'(16'd20));
    no_idle = 1'b1;
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_DOWN);
    repeat (24) send_item(OP_TICK, '0, '0);
    send_item(OP_KEY, key_of(IDX_LEFT), KEY_UP);
    no_idle = 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup(ph);
      no_idle = (ph == 5);
      if (ph == 3) hold_off_req = 1'b1;
      target = n_offered + PHASE_N;
      while (n_offered < target) begin
        if ($urandom_range(9) < 6) press_gesture();
        else noise_item();
      end
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("run: %0d items, %0d results, %0d tap-double holds committed",
             n_items, n_results, n_commits);
    $display("run: table and hold extremes, result limit, tick-driven hold, long output stall");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
